FILE: rtl/dlsc_pkg.sv
`default_nettype none

package dlsc_pkg;

    localparam int TABLE_DEPTH     = 16;
    localparam int CHANNEL_COUNT   = 4;
    localparam int IW              = $clog2(TABLE_DEPTH);
    localparam int LW              = $clog2(TABLE_DEPTH + 1);
    localparam int SW              = IW + 2;
    localparam int CW              = $clog2(CHANNEL_COUNT);
    localparam int LEVEL_CAP       = 100;
    localparam int YELLOW_AT_RESET = 20;

    localparam logic CAUSE_SCHEDULE = 1'b0;
    localparam logic CAUSE_MANUAL   = 1'b1;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_ADJUST = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SEARCH,
        ST_PICK
    } state_t;

    typedef struct packed {
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] white;
        logic [7:0] yellow;
    } entry_t;

    typedef struct packed {
        logic          wr_en;
        logic [IW-1:0] wr_index;
        entry_t        wr_entry;
        logic [4:0]    hour;
        logic [5:0]    minute;
    } row_ctrl_t;

    typedef struct packed {
        logic [TABLE_DEPTH-1:0] gt;
        logic [TABLE_DEPTH-1:0] eq;
        logic [LW-1:0]          table_len;
    } row_status_t;

    function automatic entry_t default_entry(input int k);
        entry_t e;
        case (k)
            0:       e = '{8'd7,  8'd30, 8'd0, 8'd5};
            1:       e = '{8'd7,  8'd40, 8'd0, 8'd10};
            2:       e = '{8'd7,  8'd50, 8'd1, 8'd15};
            3:       e = '{8'd8,  8'd0,  8'd2, 8'd20};
            4:       e = '{8'd10, 8'd0,  8'd5, 8'd20};
            5:       e = '{8'd12, 8'd0,  8'd7, 8'd25};
            6:       e = '{8'd15, 8'd0,  8'd5, 8'd20};
            7:       e = '{8'd17, 8'd0,  8'd2, 8'd20};
            8:       e = '{8'd18, 8'd0,  8'd1, 8'd17};
            9:       e = '{8'd19, 8'd0,  8'd0, 8'd17};
            10:      e = '{8'd20, 8'd0,  8'd0, 8'd15};
            11:      e = '{8'd21, 8'd0,  8'd0, 8'd10};
            12:      e = '{8'd22, 8'd0,  8'd0, 8'd5};
            13:      e = '{8'd23, 8'd0,  8'd0, 8'd0};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dlsc_if.sv
`default_nettype none

interface dlsc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [4:0]        tick_hour;
    logic [5:0]        minute_now;
    logic [3:0]        entry_index;
    logic [7:0]        entry_hour;
    logic [7:0]        entry_minute;
    logic [7:0]        entry_white;
    logic [7:0]        entry_yellow;
    logic [1:0]        channel;
    logic signed [7:0] delta;

    modport source (
        output valid, action, tick_hour, minute_now, entry_index, entry_hour,
               entry_minute, entry_white, entry_yellow, channel, delta,
        input  ready
    );
    modport sink (
        input  valid, action, tick_hour, minute_now, entry_index, entry_hour,
               entry_minute, entry_white, entry_yellow, channel, delta,
        output ready
    );
endinterface

interface dlsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] level_white;
    logic [7:0] level_yellow;
    logic [7:0] level_third;
    logic [7:0] level_fourth;
    logic [3:0] active_entry;
    logic       cause;

    modport source (
        output valid, level_white, level_yellow, level_third, level_fourth,
               active_entry, cause,
        input  ready
    );
    modport sink (
        input  valid, level_white, level_yellow, level_third, level_fourth,
               active_entry, cause,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/dlsc_cell.sv
`default_nettype none

module dlsc_cell
    import dlsc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [IW-1:0] cell_index,
    input  wire entry_t        entry,
    input  wire logic [4:0]    hour,
    input  wire logic [5:0]    minute,
    input  wire logic          live_in,
    input  wire logic [LW-1:0] len_in,
    output logic               live,
    output logic [LW-1:0]      len,
    output logic               gt,
    output logic               eq
);

    logic          live_reg, live_next;
    logic [LW-1:0] len_reg, len_next;
    logic          gt_reg, gt_next;
    logic          eq_reg, eq_next;
    logic [7:0]    h8;
    logic [7:0]    m8;

    always_comb
    begin
        h8        = {3'b000, hour};
        m8        = {2'b00, minute};
        live_next = live_in && (entry != '0);
        if (live_next)
        begin
            len_next = LW'(cell_index) + LW'(1);
        end
        else if (live_in)
        begin
            len_next = LW'(cell_index);
        end
        else
        begin
            len_next = len_in;
        end
        gt_next = (h8 > entry.hour) || ((h8 == entry.hour) && (m8 > entry.minute));
        eq_next = (h8 == entry.hour) && (m8 == entry.minute);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
            len_reg  <= '0;
            gt_reg   <= 1'b0;
            eq_reg   <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            len_reg  <= len_next;
            gt_reg   <= gt_next;
            eq_reg   <= eq_next;
        end
    end

    assign live = live_reg;
    assign len  = len_reg;
    assign gt   = gt_reg;
    assign eq   = eq_reg;

endmodule

`default_nettype wire

FILE: rtl/dlsc_row.sv
`default_nettype none

module dlsc_row
    import dlsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire row_ctrl_t ctrl,
    output entry_t         entries [TABLE_DEPTH],
    output row_status_t    status
);

    entry_t                 entry_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] live;
    logic [LW-1:0]          len [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] gt;
    logic [TABLE_DEPTH-1:0] eq;

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        logic          live_in;
        logic [LW-1:0] len_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                entry_reg[k] <= default_entry(k);
            end
            else if (ctrl.wr_en && (ctrl.wr_index == IW'(k)))
            begin
                entry_reg[k] <= ctrl.wr_entry;
            end
        end

        if (k == 0)
        begin : g_head
            assign live_in = 1'b1;
            assign len_in  = '0;
        end
        else
        begin : g_link
            assign live_in = live[k-1];
            assign len_in  = len[k-1];
        end

        dlsc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IW'(k)),
            .entry      (entry_reg[k]),
            .hour       (ctrl.hour),
            .minute     (ctrl.minute),
            .live_in    (live_in),
            .len_in     (len_in),
            .live       (live[k]),
            .len        (len[k]),
            .gt         (gt[k]),
            .eq         (eq[k])
        );

        assign entries[k] = entry_reg[k];
    end

    assign status.gt        = gt;
    assign status.eq        = eq;
    assign status.table_len = len[TABLE_DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/daily_light_schedule_controller_core.sv
// Write and adjust transfers complete when accepted; an adjust result is valid the cycle after.
// A tick first lets the length wave cross the cell row in ST_SWEEP, then runs a binary
// search in ST_SEARCH and chooses the entry in ST_PICK; an empty table ends it after the sweep.
// One item is in flight at a time; input ready waits until the output register is taken.
// Reset loads the fourteen default schedule entries at once, yellow level 20, no entry chosen.
`default_nettype none

module daily_light_schedule_controller_core
    import dlsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dlsc_in_if.sink   in_ch,
    dlsc_out_if.source out_ch
);

    state_t                state_reg, state_next;
    logic signed [SW-1:0]  lo_reg, lo_next;
    logic signed [SW-1:0]  hi_reg, hi_next;
    logic [IW-1:0]         pick_reg, pick_next;
    logic [LW-1:0]         sweep_reg, sweep_next;
    logic [IW-1:0]         last_reg, last_next;
    logic                  last_valid_reg, last_valid_next;
    logic [7:0]            lvl_reg [CHANNEL_COUNT];
    logic [7:0]            lvl_next [CHANNEL_COUNT];
    logic [4:0]            hour_reg;
    logic [5:0]            minute_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_white_reg, out_yellow_reg, out_third_reg, out_fourth_reg;
    logic [3:0]            out_entry_reg;
    logic                  out_cause_reg;

    row_ctrl_t             ctrl;
    row_status_t           row_st;
    entry_t                entries [TABLE_DEPTH];

    logic                  in_accept;
    logic                  emit;
    logic                  emit_cause;
    logic signed [SW-1:0]  mid_sum;
    logic [IW-1:0]         mid;
    logic [IW-1:0]         chosen;
    logic [LW-1:0]         len_m1;
    logic [CW-1:0]         ch_idx;
    logic [7:0]            ch_level;
    logic [8:0]            mag;
    logic [8:0]            sum;
    logic [7:0]            adj_level;

    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_accept   = in_ch.valid && in_ch.ready;

    dlsc_row u_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .entries (entries),
        .status  (row_st)
    );

    always_comb
    begin
        ch_idx   = in_ch.channel[CW-1:0];
        ch_level = lvl_reg[ch_idx];
        mag      = 9'd256 - {1'b0, $unsigned(in_ch.delta)};
        sum      = {1'b0, ch_level} + {1'b0, $unsigned(in_ch.delta)};
        if (in_ch.delta[7])
        begin
            adj_level = ({1'b0, ch_level} > mag) ? 8'({1'b0, ch_level} - mag) : 8'd0;
        end
        else
        begin
            adj_level = (sum > 9'(LEVEL_CAP)) ? 8'(LEVEL_CAP) : sum[7:0];
        end

        mid_sum = lo_reg + hi_reg;
        mid     = mid_sum[IW:1];
        len_m1  = row_st.table_len - LW'(1);
        chosen  = (row_st.gt[pick_reg] || row_st.eq[pick_reg]) ? pick_reg : len_m1[IW-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pick_next       = pick_reg;
        sweep_next      = sweep_reg;
        last_next       = last_reg;
        last_valid_next = last_valid_reg;
        lvl_next        = lvl_reg;
        emit            = 1'b0;
        emit_cause      = CAUSE_SCHEDULE;

        ctrl.wr_en           = 1'b0;
        ctrl.wr_index        = in_ch.entry_index[IW-1:0];
        ctrl.wr_entry.hour   = in_ch.entry_hour;
        ctrl.wr_entry.minute = in_ch.entry_minute;
        ctrl.wr_entry.white  = in_ch.entry_white;
        ctrl.wr_entry.yellow = in_ch.entry_yellow;
        ctrl.hour            = hour_reg;
        ctrl.minute          = minute_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (action_t'(in_ch.action))
                        ACT_TICK:
                        begin
                            sweep_next = '0;
                            state_next = ST_SWEEP;
                        end
                        ACT_WRITE:
                        begin
                            ctrl.wr_en = (32'(in_ch.entry_index) < TABLE_DEPTH);
                        end
                        ACT_ADJUST:
                        begin
                            if (32'(in_ch.channel) < CHANNEL_COUNT)
                            begin
                                lvl_next[ch_idx] = adj_level;
                                emit             = 1'b1;
                                emit_cause       = CAUSE_MANUAL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                sweep_next = sweep_reg + LW'(1);
                if (sweep_reg == LW'(TABLE_DEPTH - 1))
                begin
                    if (row_st.table_len == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = SW'(row_st.table_len) - SW'(1);
                        pick_next  = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg > hi_reg)
                begin
                    state_next = ST_PICK;
                end
                else if (row_st.gt[mid])
                begin
                    pick_next = mid;
                    lo_next   = SW'(mid) + SW'(1);
                end
                else if (row_st.eq[mid])
                begin
                    pick_next  = mid;
                    state_next = ST_PICK;
                end
                else
                begin
                    hi_next = SW'(mid) - SW'(1);
                end
            end
            ST_PICK:
            begin
                state_next = ST_IDLE;
                if (!(last_valid_reg && (chosen == last_reg)))
                begin
                    lvl_next[0]     = entries[chosen].white;
                    lvl_next[1]     = entries[chosen].yellow;
                    last_next       = chosen;
                    last_valid_next = 1'b1;
                    emit            = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lo_reg         <= '0;
            hi_reg         <= '0;
            pick_reg       <= '0;
            sweep_reg      <= '0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                lvl_reg[c] <= (c == 1) ? 8'(YELLOW_AT_RESET) : 8'd0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            pick_reg       <= pick_next;
            sweep_reg      <= sweep_next;
            last_reg       <= last_next;
            last_valid_reg <= last_valid_next;
            lvl_reg        <= lvl_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold tick time and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && (action_t'(in_ch.action) == ACT_TICK))
        begin
            hour_reg   <= in_ch.tick_hour;
            minute_reg <= in_ch.minute_now;
        end
        if (emit)
        begin
            out_white_reg  <= lvl_next[0];
            out_yellow_reg <= lvl_next[1];
            out_third_reg  <= lvl_next[2];
            out_fourth_reg <= lvl_next[3];
            out_entry_reg  <= 4'(last_next);
            out_cause_reg  <= emit_cause;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.level_white  = out_white_reg;
    assign out_ch.level_yellow = out_yellow_reg;
    assign out_ch.level_third  = out_third_reg;
    assign out_ch.level_fourth = out_fourth_reg;
    assign out_ch.active_entry = out_entry_reg;
    assign out_ch.cause        = out_cause_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb
    import dlsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         DEFAULT_COUNT = 14;
    localparam int         RANDOM_ITEMS  = 1550;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         IDLE_PCT      = 15;

    localparam logic [31:0] DEFAULT_SCHED [DEFAULT_COUNT] = '{
        {8'd7,  8'd30, 8'd0, 8'd5},  {8'd7,  8'd40, 8'd0, 8'd10},
        {8'd7,  8'd50, 8'd1, 8'd15}, {8'd8,  8'd0,  8'd2, 8'd20},
        {8'd10, 8'd0,  8'd5, 8'd20}, {8'd12, 8'd0,  8'd7, 8'd25},
        {8'd15, 8'd0,  8'd5, 8'd20}, {8'd17, 8'd0,  8'd2, 8'd20},
        {8'd18, 8'd0,  8'd1, 8'd17}, {8'd19, 8'd0,  8'd0, 8'd17},
        {8'd20, 8'd0,  8'd0, 8'd15}, {8'd21, 8'd0,  8'd0, 8'd10},
        {8'd22, 8'd0,  8'd0, 8'd5},  {8'd23, 8'd0,  8'd0, 8'd0}
    };

    typedef struct packed {
        logic [1:0]        action;
        logic [4:0]        tick_hour;
        logic [5:0]        minute_now;
        logic [3:0]        entry_index;
        entry_t            entry;
        logic [1:0]        channel;
        logic signed [7:0] delta;
    } light_cmd_t;

    typedef struct packed {
        logic [7:0] white;
        logic [7:0] yellow;
        logic [7:0] third;
        logic [7:0] fourth;
        logic [3:0] active_entry;
        logic       cause;
    } light_levels_t;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_SILENT,
        ROW_TYPED
    } row_check_t;

    typedef struct {
        light_cmd_t    cmd;
        row_check_t    check;
        light_levels_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    dlsc_in_if  in_ch ();
    dlsc_out_if out_ch ();

    daily_light_schedule_controller_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    entry_t        sched_now [TABLE_DEPTH];
    logic [7:0]    lamp [CHANNEL_COUNT];
    int            entry_in_force;
    bit            entry_chosen;
    light_levels_t pending_levels [$];
    plan_row_t     plan [$];
    int            mismatch_count;
    int            items_done;
    int            quiet_cycles;
    bit            no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic light_cmd_t mk_tick(input int h, input int m);
        light_cmd_t c;
        c            = '0;
        c.action     = ACT_TICK;
        c.tick_hour  = 5'(h);
        c.minute_now = 6'(m);
        return c;
    endfunction

    function automatic light_cmd_t mk_write(input int idx, input int h, input int m,
                                            input int w, input int y);
        light_cmd_t c;
        c             = '0;
        c.action      = ACT_WRITE;
        c.entry_index = 4'(idx);
        c.entry       = {8'(h), 8'(m), 8'(w), 8'(y)};
        return c;
    endfunction

    function automatic light_cmd_t mk_adjust(input int ch, input int d);
        light_cmd_t c;
        c         = '0;
        c.action  = ACT_ADJUST;
        c.channel = 2'(ch);
        c.delta   = 8'(d);
        return c;
    endfunction

    function automatic light_levels_t levels_of(input int w, input int y, input int t,
                                                input int f, input int e, input int cs);
        light_levels_t r;
        r.white        = 8'(w);
        r.yellow       = 8'(y);
        r.third        = 8'(t);
        r.fourth       = 8'(f);
        r.active_entry = 4'(e);
        r.cause        = 1'(cs);
        return r;
    endfunction

    function automatic string levels_text(input light_levels_t v);
        return $sformatf("%0d %0d %0d %0d entry %0d cause %0d", v.white, v.yellow,
                         v.third, v.fourth, v.active_entry, v.cause);
    endfunction

    function automatic void reset_schedule();
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if (k < DEFAULT_COUNT)
                sched_now[k] = DEFAULT_SCHED[k];
            else
                sched_now[k] = '0;
        end
        for (int k = 0; k < CHANNEL_COUNT; k++)
            lamp[k] = 8'd0;
        lamp[1]        = 8'(YELLOW_AT_RESET);
        entry_in_force = 0;
        entry_chosen   = 1'b0;
    endfunction

    function automatic int time_order(input logic [4:0] h, input logic [5:0] m,
                                      input entry_t e);
        if (int'(h) != int'(e.hour))
            return int'(h) > int'(e.hour) ? 1 : -1;
        if (int'(m) != int'(e.minute))
            return int'(m) > int'(e.minute) ? 1 : -1;
        return 0;
    endfunction

    function automatic logic [7:0] chan_level(input int k);
        return k < CHANNEL_COUNT ? lamp[k] : 8'd0;
    endfunction

    function automatic light_levels_t emit_levels(input logic cs);
        return levels_of(chan_level(0), chan_level(1), chan_level(2), chan_level(3),
                         entry_in_force, cs);
    endfunction

    function automatic bit next_levels(input light_cmd_t c, output light_levels_t r);
        int n;
        int lo;
        int hi;
        int mid;
        int pick;
        int chosen;
        int cmp;
        int lvl;
        int mag;
        int d;
        bit hit;
        r = '0;
        case (c.action)
            ACT_TICK:
            begin
                n = TABLE_DEPTH;
                for (int k = TABLE_DEPTH - 1; k >= 0; k--)
                    if (sched_now[k] == '0)
                        n = k;
                if (n == 0)
                    return 1'b0;
                lo   = 0;
                hi   = n - 1;
                pick = 0;
                hit  = 1'b0;
                while (lo <= hi && !hit)
                begin
                    mid = (lo + hi) / 2;
                    cmp = time_order(c.tick_hour, c.minute_now, sched_now[mid]);
                    if (cmp > 0)
                    begin
                        pick = mid;
                        lo   = mid + 1;
                    end
                    else if (cmp < 0)
                        hi = mid - 1;
                    else
                    begin
                        pick = mid;
                        hit  = 1'b1;
                    end
                end
                chosen = time_order(c.tick_hour, c.minute_now, sched_now[pick]) >= 0 ?
                         pick : n - 1;
                if (entry_chosen && chosen == entry_in_force)
                    return 1'b0;
                lamp[0]        = sched_now[chosen].white;
                lamp[1]        = sched_now[chosen].yellow;
                entry_in_force = chosen;
                entry_chosen   = 1'b1;
                r = emit_levels(CAUSE_SCHEDULE);
                return 1'b1;
            end
            ACT_WRITE:
            begin
                if (int'(c.entry_index) < TABLE_DEPTH)
                    sched_now[c.entry_index] = c.entry;
                return 1'b0;
            end
            ACT_ADJUST:
            begin
                if (int'(c.channel) >= CHANNEL_COUNT)
                    return 1'b0;
                lvl = int'(lamp[c.channel]);
                d   = int'($signed(c.delta));
                if (d < 0)
                begin
                    mag = -d;
                    lvl = lvl > mag ? lvl - mag : 0;
                end
                else
                    lvl = lvl + d > LEVEL_CAP ? LEVEL_CAP : lvl + d;
                lamp[c.channel] = 8'(lvl);
                r = emit_levels(CAUSE_MANUAL);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic flag(input string what, input light_levels_t want,
                        input light_levels_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected %s, got %s", what, levels_text(want), levels_text(got));
    endtask

    task automatic send_cmd(input light_cmd_t c, input row_check_t chk,
                            input light_levels_t want);
        light_levels_t r;
        bit produced;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.action       <= c.action;
        in_ch.tick_hour    <= c.tick_hour;
        in_ch.minute_now   <= c.minute_now;
        in_ch.entry_index  <= c.entry_index;
        in_ch.entry_hour   <= c.entry.hour;
        in_ch.entry_minute <= c.entry.minute;
        in_ch.entry_white  <= c.entry.white;
        in_ch.entry_yellow <= c.entry.yellow;
        in_ch.channel      <= c.channel;
        in_ch.delta        <= c.delta;
        do @(posedge clk); while (!in_ch.ready);
        produced = next_levels(c, r);
        case (chk)
            ROW_MODEL:
                if (produced)
                    pending_levels.push_back(r);
            ROW_TYPED:
                pending_levels.push_back(want);
            default:
                ;
        endcase
        if (c.action != ACT_UNUSED)
            items_done++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(negedge clk);
    endtask

    task automatic reload_schedule();
        int n;
        int t;
        n = $urandom_range(1, TABLE_DEPTH);
        t = $urandom_range(0, 90);
        for (int k = 0; k < n; k++)
        begin
            send_cmd(mk_write(k, t / 60, t % 60, $urandom_range(0, 255),
                              $urandom_range(0, 255)), ROW_MODEL, '0);
            t += $urandom_range(1, 2880 / n);
        end
        if (n < TABLE_DEPTH && $urandom_range(0, 3) != 0)
            send_cmd(mk_write(n, 0, 0, 0, 0), ROW_MODEL, '0);
    endtask

    task automatic traffic_burst();
        int len;
        int r;
        light_cmd_t c;
        len = $urandom_range(10, 30);
        for (int k = 0; k < len; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                if ($urandom_range(0, 99) < 85)
                    c = mk_tick($urandom_range(0, 23), $urandom_range(0, 59));
                else
                    c = mk_tick($urandom_range(0, 31), $urandom_range(0, 63));
            end
            else if (r < 90)
            begin
                if ($urandom_range(0, 1) == 0)
                    c = mk_adjust($urandom_range(0, 3), $urandom_range(0, 255));
                else
                    c = mk_adjust($urandom_range(0, 3), int'($urandom_range(0, 20)) - 10);
            end
            else if (r < 95)
                c = mk_write($urandom_range(0, 15), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
            else
            begin
                c = mk_write($urandom_range(0, 15), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
                c.tick_hour  = 5'($urandom);
                c.minute_now = 6'($urandom);
                c.channel    = 2'($urandom);
                c.delta      = 8'($urandom);
                c.action     = ACT_UNUSED;
            end
            send_cmd(c, ROW_MODEL, '0);
        end
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        light_levels_t got;
        light_levels_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = levels_of(out_ch.level_white, out_ch.level_yellow, out_ch.level_third,
                            out_ch.level_fourth, out_ch.active_entry, out_ch.cause);
            if (pending_levels.size() == 0)
                flag("result with nothing pending", '0, got);
            else
            begin
                want = pending_levels.pop_front();
                if (got.white != want.white || got.yellow != want.yellow ||
                    got.third != want.third || got.fourth != want.fourth ||
                    got.active_entry != want.active_entry || got.cause != want.cause)
                    flag("level mismatch", want, got);
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        bit paused;
        int pick;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_TICK;
        in_ch.tick_hour    = '0;
        in_ch.minute_now   = '0;
        in_ch.entry_index  = '0;
        in_ch.entry_hour   = '0;
        in_ch.entry_minute = '0;
        in_ch.entry_white  = '0;
        in_ch.entry_yellow = '0;
        in_ch.channel      = '0;
        in_ch.delta        = '0;
        mismatch_count     = 0;
        items_done         = 0;
        quiet_cycles       = 0;
        no_idle            = 1'b0;
        paused             = 1'b0;
        reset_schedule();

        plan.push_back('{mk_adjust(0, 0),    ROW_TYPED,  levels_of(0, 20, 0, 0, 0, CAUSE_MANUAL)});
        plan.push_back('{mk_tick(0, 0),      ROW_TYPED,  levels_of(0, 0, 0, 0, 13, CAUSE_SCHEDULE)});
        plan.push_back('{mk_tick(23, 59),    ROW_SILENT, '0});
        plan.push_back('{mk_tick(7, 30),     ROW_TYPED,  levels_of(0, 5, 0, 0, 0, CAUSE_SCHEDULE)});
        plan.push_back('{mk_tick(7, 29),     ROW_TYPED,  levels_of(0, 0, 0, 0, 13, CAUSE_SCHEDULE)});
        plan.push_back('{mk_tick(12, 0),     ROW_TYPED,  levels_of(7, 25, 0, 0, 5, CAUSE_SCHEDULE)});
        plan.push_back('{mk_adjust(2, 127),  ROW_TYPED,  levels_of(7, 25, 100, 0, 5, CAUSE_MANUAL)});
        plan.push_back('{mk_adjust(2, -128), ROW_TYPED,  levels_of(7, 25, 0, 0, 5, CAUSE_MANUAL)});
        plan.push_back('{mk_adjust(3, 100),  ROW_TYPED,  levels_of(7, 25, 0, 100, 5, CAUSE_MANUAL)});
        plan.push_back('{mk_adjust(3, -1),   ROW_TYPED,  levels_of(7, 25, 0, 99, 5, CAUSE_MANUAL)});
        plan.push_back('{mk_adjust(0, -128), ROW_TYPED,  levels_of(0, 25, 0, 99, 5, CAUSE_MANUAL)});
        plan.push_back('{light_cmd_t'('1),   ROW_SILENT, '0});
        plan.push_back('{mk_tick(31, 63),    ROW_TYPED,  levels_of(0, 0, 0, 99, 13, CAUSE_SCHEDULE)});
        plan.push_back('{mk_write(15, 255, 255, 255, 255), ROW_SILENT, '0});
        plan.push_back('{mk_write(14, 23, 59, 255, 255),   ROW_SILENT, '0});
        plan.push_back('{mk_tick(23, 59),    ROW_MODEL,  '0});
        plan.push_back('{mk_adjust(1, 1),    ROW_MODEL,  '0});
        plan.push_back('{mk_adjust(0, -1),   ROW_MODEL,  '0});
        plan.push_back('{mk_write(0, 0, 0, 0, 0), ROW_SILENT, '0});
        plan.push_back('{mk_tick(10, 0),     ROW_SILENT, '0});
        plan.push_back('{mk_adjust(1, 0),    ROW_MODEL,  '0});
        plan.push_back('{mk_write(0, 0, 0, 0, 1), ROW_SILENT, '0});
        plan.push_back('{mk_tick(0, 0),      ROW_MODEL,  '0});
        plan.push_back('{mk_write(5, 1, 0, 9, 9), ROW_SILENT, '0});
        plan.push_back('{mk_tick(9, 0),      ROW_MODEL,  '0});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_cmd(plan[i].cmd, plan[i].check, plan[i].want);

        items_done = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            no_idle = items_done >= 600 && items_done < 900;
            pick = $urandom_range(0, 9);
            if (pick < 2)
                reload_schedule();
            else if (pick < 9)
                traffic_burst();
            else
                send_cmd(mk_write($urandom_range(0, 2), 0, 0, 0, 0), ROW_MODEL, '0);
            if ((!paused && items_done >= 400) || (pick == 0 && $urandom_range(0, 3) == 0))
            begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
        no_idle = 1'b0;

        hold_until_drained();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && pending_levels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
